// File: rtl/core/rcfd_pkg.sv
// shared types, constants and helper functions for the remote control frame decoder
`default_nettype none

package rcfd_pkg;

    // input word operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_TIMEOUT   = 2'd0;
    localparam cfg_index_t REG_DEAD_ZONE = 2'd1;

    localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
    localparam logic [9:0]  DEAD_ZONE_RESET = 10'd20;

    // frame gathering
    localparam logic [4:0] FRAME_LEN   = 5'd18;
    localparam logic [4:0] COUNT_MAX   = 5'd31;
    localparam int         STORE_IDX_W = 4;
    localparam logic [4:0] STORE_DEPTH = 5'd16;
    localparam logic [15:0] TICK_MAX   = 16'hFFFF;

    // stick scaling: q = (mag * 32768 + 330) / 660 via a rounded-up reciprocal of 2^35 / 660
    localparam logic [10:0] STICK_MID   = 11'd1024;
    localparam logic [25:0] ROUND_HALF  = 26'd330;
    localparam logic [25:0] RECIP       = 26'd52060210;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [14:0] Q15_MAX     = 15'h7FFF;

    // switch codes
    localparam logic [1:0] SW_UP_RAW  = 2'd1;
    localparam logic [1:0] SW_MID_RAW = 2'd3;
    localparam logic [1:0] SW_UP      = 2'd0;
    localparam logic [1:0] SW_MID     = 2'd1;
    localparam logic [1:0] SW_DOWN    = 2'd2;

    localparam int NUM_STICKS = 4;
    localparam int NUM_WORDS  = 5;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [QUEUE_PTR_W:0] QUEUE_FULL = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic       frame_end;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] stick0;
        logic signed [15:0] stick1;
        logic signed [15:0] stick2;
        logic signed [15:0] stick3;
        logic [1:0]         switch_left;
        logic [1:0]         switch_right;
        logic signed [15:0] mouse_dx;
        logic signed [15:0] mouse_dy;
        logic signed [15:0] mouse_dz;
        logic [15:0]        mouse_buttons;
        logic [15:0]        key_bits;
        logic               stop;
    } out_word_t;

    // one queued result: raw frame fields or a link-loss marker
    typedef struct packed {
        logic                             lost;
        logic [NUM_STICKS-1:0][10:0]      raw;
        logic [3:0]                       sw_raw;
        logic [NUM_WORDS-1:0][15:0]       word;
    } q_entry_t;

    // fields that ride along the scaling pipeline untouched
    typedef struct packed {
        logic                       lost;
        logic [1:0]                 sw_left;
        logic [1:0]                 sw_right;
        logic [NUM_WORDS-1:0][15:0] word;
    } side_t;

    function automatic logic [1:0] decode_switch(input logic [1:0] raw);
        logic [1:0] code;
        case (raw)
            SW_UP_RAW:  code = SW_UP;
            SW_MID_RAW: code = SW_MID;
            default:    code = SW_DOWN;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rcfd_front.sv
// front end: frame gathering, length check and link watchdog
`default_nettype none

module rcfd_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rcfd_pkg::in_word_t in_word,
    input  wire logic [15:0]        timeout_ticks,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output rcfd_pkg::q_entry_t      push_entry
);

    logic [4:0]  byte_count_reg, byte_count_next;
    logic [15:0] idle_ticks_reg, idle_ticks_next;
    logic        link_up_reg, link_up_next;
    logic [7:0]  frame_store_reg [16];

    logic        accept;
    logic        is_byte;
    logic        is_tick;
    logic [4:0]  count_inc;
    logic [15:0] idle_inc;
    logic        good_frame;
    logic        link_lost;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign is_byte  = accept && (in_word.op == rcfd_pkg::OP_BYTE);
    assign is_tick  = accept && (in_word.op == rcfd_pkg::OP_TICK);

    always_comb
    begin
        count_inc = (byte_count_reg < rcfd_pkg::COUNT_MAX) ? byte_count_reg + 5'd1
                                                           : byte_count_reg;
        idle_inc  = (idle_ticks_reg < rcfd_pkg::TICK_MAX) ? idle_ticks_reg + 16'd1
                                                          : idle_ticks_reg;
        good_frame = is_byte && in_word.frame_end && (count_inc == rcfd_pkg::FRAME_LEN);
        link_lost  = is_tick && link_up_reg && (idle_inc > timeout_ticks);

        byte_count_next = byte_count_reg;
        idle_ticks_next = idle_ticks_reg;
        link_up_next    = link_up_reg;
        if (is_byte)
        begin
            byte_count_next = in_word.frame_end ? 5'd0 : count_inc;
        end
        if (good_frame)
        begin
            idle_ticks_next = 16'd0;
            link_up_next    = 1'b1;
        end
        if (is_tick)
        begin
            idle_ticks_next = idle_inc;
        end
        if (link_lost)
        begin
            link_up_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 5'd0;
            idle_ticks_reg <= 16'd0;
            link_up_reg    <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            idle_ticks_reg <= idle_ticks_next;
            link_up_reg    <= link_up_next;
        end
    end

    // the last two frame bytes are never reported, so only sixteen are kept
    always_ff @(posedge clk)
    begin
        if (is_byte && (byte_count_reg < rcfd_pkg::STORE_DEPTH))
        begin
            frame_store_reg[byte_count_reg[rcfd_pkg::STORE_IDX_W-1:0]] <= in_word.rx_byte;
        end
    end

    always_comb
    begin
        push_valid = good_frame || link_lost;
        push_entry = '0;
        if (link_lost)
        begin
            push_entry.lost = 1'b1;
        end
        else
        begin
            push_entry.raw[0] = {frame_store_reg[1][2:0], frame_store_reg[0]};
            push_entry.raw[1] = {frame_store_reg[2][5:0], frame_store_reg[1][7:3]};
            push_entry.raw[2] = {frame_store_reg[4][0], frame_store_reg[3],
                                 frame_store_reg[2][7:6]};
            push_entry.raw[3] = {frame_store_reg[5][3:0], frame_store_reg[4][7:1]};
            push_entry.sw_raw = frame_store_reg[5][7:4];
            for (int w = 0; w < rcfd_pkg::NUM_WORDS; w++)
            begin
                push_entry.word[w] = {frame_store_reg[2*w+7], frame_store_reg[2*w+6]};
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rcfd_queue.sv
// two-entry result queue between front end and scaling back end
`default_nettype none

module rcfd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire rcfd_pkg::q_entry_t push_entry,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output rcfd_pkg::q_entry_t      pop_entry
);

    rcfd_pkg::q_entry_t              mem_reg [rcfd_pkg::QUEUE_DEPTH];
    logic [rcfd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rcfd_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rcfd_pkg::QUEUE_PTR_W:0]   count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = (count_reg != rcfd_pkg::QUEUE_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rcfd_back.sv
// back end: stick dead zone and scaling pipeline, switch decode, output register
`default_nettype none

module rcfd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [9:0]         dead_zone,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire rcfd_pkg::q_entry_t pop_entry,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rcfd_pkg::out_word_t     out_word
);

    // stage a: magnitude, sign, dead zone flag, rounded numerator
    logic                a_valid_reg;
    logic [25:0]         a_num_reg  [rcfd_pkg::NUM_STICKS];
    logic                a_neg_reg  [rcfd_pkg::NUM_STICKS];
    logic                a_zero_reg [rcfd_pkg::NUM_STICKS];
    rcfd_pkg::side_t     a_side_reg;
    logic [25:0]         a_num_next  [rcfd_pkg::NUM_STICKS];
    logic                a_neg_next  [rcfd_pkg::NUM_STICKS];
    logic                a_zero_next [rcfd_pkg::NUM_STICKS];
    rcfd_pkg::side_t     a_side_next;

    // stage b: quotient from reciprocal product
    logic                b_valid_reg;
    logic [15:0]         b_q_reg    [rcfd_pkg::NUM_STICKS];
    logic                b_neg_reg  [rcfd_pkg::NUM_STICKS];
    logic                b_zero_reg [rcfd_pkg::NUM_STICKS];
    rcfd_pkg::side_t     b_side_reg;
    logic [15:0]         b_q_next   [rcfd_pkg::NUM_STICKS];

    logic                out_valid_reg;
    rcfd_pkg::out_word_t out_word_reg, out_word_next;

    logic free_o;
    logic free_b;
    logic free_a;

    assign free_o    = !out_valid_reg || out_ready;
    assign free_b    = !b_valid_reg || free_o;
    assign free_a    = !a_valid_reg || free_b;
    assign pop_ready = free_a;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        logic [10:0] raw;
        logic [10:0] mag;
        for (int k = 0; k < rcfd_pkg::NUM_STICKS; k++)
        begin
            raw = pop_entry.raw[k];
            if (raw >= rcfd_pkg::STICK_MID)
            begin
                mag           = raw - rcfd_pkg::STICK_MID;
                a_neg_next[k] = 1'b0;
            end
            else
            begin
                mag           = rcfd_pkg::STICK_MID - raw;
                a_neg_next[k] = 1'b1;
            end
            a_zero_next[k] = (mag < {1'b0, dead_zone});
            a_num_next[k]  = {mag, 15'd0} + rcfd_pkg::ROUND_HALF;
        end
        a_side_next.lost     = pop_entry.lost;
        a_side_next.sw_left  = rcfd_pkg::decode_switch(pop_entry.sw_raw[3:2]);
        a_side_next.sw_right = rcfd_pkg::decode_switch(pop_entry.sw_raw[1:0]);
        a_side_next.word     = pop_entry.word;
    end

    always_comb
    begin
        logic [51:0] prod;
        for (int k = 0; k < rcfd_pkg::NUM_STICKS; k++)
        begin
            prod        = a_num_reg[k] * rcfd_pkg::RECIP;
            b_q_next[k] = prod[rcfd_pkg::RECIP_SHIFT +: 16];
        end
    end

    always_comb
    begin
        logic [14:0]        sat;
        logic signed [15:0] val [rcfd_pkg::NUM_STICKS];
        for (int k = 0; k < rcfd_pkg::NUM_STICKS; k++)
        begin
            sat = (b_q_reg[k] > {1'b0, rcfd_pkg::Q15_MAX}) ? rcfd_pkg::Q15_MAX
                                                           : b_q_reg[k][14:0];
            if (b_zero_reg[k])
            begin
                val[k] = 16'sd0;
            end
            else if (b_neg_reg[k])
            begin
                val[k] = -$signed({1'b0, sat});
            end
            else
            begin
                val[k] = $signed({1'b0, sat});
            end
        end
        out_word_next.stick0        = val[0];
        out_word_next.stick1        = val[1];
        out_word_next.stick2        = val[2];
        out_word_next.stick3        = val[3];
        out_word_next.switch_left   = b_side_reg.sw_left;
        out_word_next.switch_right  = b_side_reg.sw_right;
        out_word_next.mouse_dx      = b_side_reg.word[0];
        out_word_next.mouse_dy      = b_side_reg.word[1];
        out_word_next.mouse_dz      = b_side_reg.word[2];
        out_word_next.mouse_buttons = b_side_reg.word[3];
        out_word_next.key_bits      = b_side_reg.word[4];
        out_word_next.stop          = (b_side_reg.sw_right == rcfd_pkg::SW_DOWN);
        if (b_side_reg.lost)
        begin
            out_word_next              = '0;
            out_word_next.switch_left  = rcfd_pkg::SW_DOWN;
            out_word_next.switch_right = rcfd_pkg::SW_DOWN;
            out_word_next.stop         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (free_a)
            begin
                a_valid_reg <= pop_valid;
            end
            if (free_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (free_o)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free_a)
        begin
            a_num_reg  <= a_num_next;
            a_neg_reg  <= a_neg_next;
            a_zero_reg <= a_zero_next;
            a_side_reg <= a_side_next;
        end
        if (free_b)
        begin
            b_q_reg    <= b_q_next;
            b_neg_reg  <= a_neg_reg;
            b_zero_reg <= a_zero_reg;
            b_side_reg <= a_side_reg;
        end
        if (free_o)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/remote_control_frame_decoder.sv
// top level of the remote control frame decoder
`default_nettype none

// Takes one input word per cycle: either a received frame byte (with a
// frame-end mark) or a time tick. A frame of exactly 18 bytes gives one
// result word with four dead-zoned, Q1.15-scaled sticks, both decoded
// switches, mouse and key words and a stop flag; any other length is dropped
// silently. When more ticks than timeout_ticks pass after the last good frame,
// one stop word with neutral fields is given and the link stays down until
// the next good frame. Sustained rate is one input word per clock while the
// queue can take entries; a result reaches out_valid through the queue and
// then the three-stage scaling pipeline (magnitude, reciprocal multiply,
// saturate into the output register). A two-deep queue between the
// front end and the pipeline lets input keep flowing while a result waits.
// Configuration writes are taken at once and must only happen while idle.

module remote_control_frame_decoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input word channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire rcfd_pkg::in_word_t            in_word,
    // result word channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output rcfd_pkg::out_word_t                out_word,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire rcfd_pkg::cfg_index_t          cfg_index,
    input  wire logic [rcfd_pkg::CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [15:0] timeout_ticks_reg;
    logic [9:0]  dead_zone_reg;

    // front end to queue
    logic               push_valid;
    logic               push_ready;
    rcfd_pkg::q_entry_t push_entry;

    // queue to back end
    logic               pop_valid;
    logic               pop_ready;
    rcfd_pkg::q_entry_t pop_entry;

    // writes to unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= rcfd_pkg::TIMEOUT_RESET;
            dead_zone_reg     <= rcfd_pkg::DEAD_ZONE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcfd_pkg::REG_TIMEOUT:   timeout_ticks_reg <= cfg_data[15:0];
                rcfd_pkg::REG_DEAD_ZONE: dead_zone_reg     <= cfg_data[9:0];
                default:                 timeout_ticks_reg <= timeout_ticks_reg;
            endcase
        end
    end

    // byte gathering, length check, watchdog
    rcfd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_word       (in_word),
        .timeout_ticks (timeout_ticks_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_entry    (push_entry)
    );

    // decouples front end from the scaling pipeline
    rcfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // stick scaling, switch decode, output register
    rcfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dead_zone (dead_zone_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

// File: rtl/core/rcfd_checker.sv
// port-level assertions for the remote control frame decoder and their bind
`default_nettype none

module rcfd_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire rcfd_pkg::out_word_t out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // stop follows the right switch for frames and link loss alike
    a_stop_rule: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.stop == (out_word.switch_right == rcfd_pkg::SW_DOWN)))
        else $error("stop does not match right switch");

    // switch codes stay within up, middle, down
    a_switch_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.switch_left != 2'd3) && (out_word.switch_right != 2'd3))
        else $error("invalid switch code");

    // saturation never reaches the most negative value
    a_stick_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.stick0 != 16'h8000) && (out_word.stick1 != 16'h8000)
                   && (out_word.stick2 != 16'h8000) && (out_word.stick3 != 16'h8000))
        else $error("stick outside q1.15 range");

endmodule

bind remote_control_frame_decoder rcfd_checker u_rcfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

`default_nettype wire
